/* hw/rtl/lsbs_pkg.sv */
// Shared types and constants of the load/store bus splitter.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package lsbs_pkg;

   // Order queue geometry; one slot stays free, so QUEUE_DEPTH-1 entries are held
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int TARGET_COUNT    = 3;
   localparam int ADDR_BYTE_SHIFT = 24;

   localparam logic [7:0] ITCM_BASE_RESET = 8'h80;
   localparam logic [7:0] DTCM_BASE_RESET = 8'h90;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITCM_BASE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DTCM_BASE = 1'd1;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      TGT_ITCM = 2'd0,
      TGT_DTCM = 2'd1,
      TGT_BUS  = 2'd2
   } target_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] cmd_address;
      logic [31:0] cmd_write_data;
      logic [3:0]  cmd_byte_enable;
      logic [4:0]  cmd_reg_index;
      logic        cmd_reg_write;
      logic [2:0]  target_cmd_ready;
      logic [2:0]  target_rsp_valid;
      logic [31:0] itcm_rsp_data;
      logic [31:0] dtcm_rsp_data;
      logic [31:0] bus_rsp_data;
      logic        rsp_ready;
   } req_type;

   typedef struct packed {
      logic [2:0]  target_cmd_valid;
      logic        target_cmd_read;
      logic [31:0] target_cmd_address;
      logic [31:0] target_cmd_write_data;
      logic [3:0]  target_cmd_byte_enable;
      logic        cmd_ready;
      logic        rsp_valid;
      logic [31:0] rsp_data;
      logic [4:0]  rsp_reg_index;
      logic        rsp_reg_write;
      logic [2:0]  target_rsp_ready;
   } rsp_type;

   // One pending transaction in the order queue
   typedef struct packed {
      logic [1:0] target_id;
      logic [4:0] reg_index;
      logic       reg_write;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

/* hw/rtl/lsbs_ifs.sv */
// Valid/ready channel interfaces of the load/store bus splitter.
// Depends on lsbs_pkg for the payload types.
`default_nettype none

interface lsbs_req_if;
   import lsbs_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lsbs_rsp_if;
   import lsbs_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lsbs_order_queue.sv */
// Response-order queue: target id and register info of pending commands.
// Depends on lsbs_pkg for the entry and status types and the depth.
`default_nettype none

module lsbs_order_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire                     pop,
   input  lsbs_pkg::entry_type     push_entry,
   output lsbs_pkg::entry_type     head,
   output lsbs_pkg::q_status_type  status
);
   import lsbs_pkg::*;

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;

   // Wrap at QUEUE_DEPTH, which need not be a power of two
   assign wr_next = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   assign status.empty = (wr_ptr_ff == rd_ptr_ff);
   assign status.full  = (wr_next == rd_ptr_ff);
   assign head         = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/load_store_bus_splitter.sv */
// Top level of the load/store bus splitter: input register, routing and
// response steering logic, result register. Depends on lsbs_pkg, lsbs_ifs, lsbs_order_queue.
`default_nettype none

// Each word on req_if is one cycle's view of the load/store side and the three
// targets; each produces exactly one word on rsp_if. The command is routed by
// address bits 31:24: a match with the ITCM base goes to target 0, else a match
// with the DTCM base to target 1, else the system bus (target 2); ITCM wins when
// both bases are equal. Commands that their target takes are logged in a
// QUEUE_DEPTH entry order queue (QUEUE_DEPTH-1 usable slots); no command is
// offered while it is full. Responses come only from the target at the queue
// head, tagged with its register info; with an empty queue the word's own
// command stands in for the head. Throughput is one word per clock while the result
// is taken; a word waits in the input register and then passes through the single
// routing stage into the result register. A stalled result holds both registers
// and drops req ready once the input register holds a word. The base registers
// reset to 0x80 and 0x90; the user must write them through csr_* only while no word
// is in flight, which the block itself does not enforce.
module load_store_bus_splitter (
   input  wire                                   clock,
   input  wire                                   reset,
   lsbs_req_if.sink                              req_if,
   lsbs_rsp_if.source                            rsp_if,
   input  wire                                   csr_write_enable,
   input  wire [lsbs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [7:0]                             csr_write_data
);
   import lsbs_pkg::*;

   // Configuration
   logic [7:0] itcm_base_ff;
   logic [7:0] dtcm_base_ff;

   // Input stage
   logic    s0_valid_ff;
   logic    s0_valid_in;
   req_type s0_data_ff;

   // Result stage
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;

   logic req_acc;
   logic out_take;
   logic adv;

   // Routing
   req_type      cur;
   logic         cmd_present;
   logic         cmd_valid;
   logic [7:0]   addr_byte;
   logic [1:0]   sel;
   logic [2:0]   sel_onehot;
   logic         wen;
   logic         ren;
   logic [1:0]   wid;
   entry_type    push_entry;
   entry_type    q_head;
   entry_type    eff_head;
   q_status_type q_status;
   rsp_type      calc;

   assign req_acc  = req_if.valid && req_if.ready;
   assign out_take = !out_valid_ff || rsp_if.ready;
   assign adv      = s0_valid_ff && out_take;

   assign req_if.ready   = !s0_valid_ff || adv;
   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   // Configuration writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         itcm_base_ff <= ITCM_BASE_RESET;
         dtcm_base_ff <= DTCM_BASE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ITCM_BASE) begin
            itcm_base_ff <= csr_write_data;
         end
         if (csr_index == CSR_DTCM_BASE) begin
            dtcm_base_ff <= csr_write_data;
         end
      end
   end

   // Hold the word in the input register until the result stage can take it
   assign s0_valid_in = req_acc ? 1'b1 : (adv ? 1'b0 : s0_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s0_data_ff <= req_if.payload;
      end
   end

   assign cur = s0_data_ff;

   // Decode and route the command; operation code 3 is no command
   assign cmd_present = (cur.operation == OP_READ) || (cur.operation == OP_WRITE);
   assign cmd_valid   = cmd_present && !q_status.full;
   assign addr_byte   = cur.cmd_address[ADDR_BYTE_SHIFT +: 8];

   always_comb begin
      priority if (addr_byte == itcm_base_ff) begin
         sel = TGT_ITCM;
      end else if (addr_byte == dtcm_base_ff) begin
         sel = TGT_DTCM;
      end else begin
         sel = TGT_BUS;
      end
   end

   always_comb begin
      unique case (sel)
         TGT_ITCM: sel_onehot = 3'b001;
         TGT_DTCM: sel_onehot = 3'b010;
         TGT_BUS:  sel_onehot = 3'b100;
         default:  sel_onehot = 3'b000;
      endcase
   end

   assign wen = cmd_valid && ((cur.target_cmd_ready & sel_onehot) != 3'b000);
   // Clear the id each word when nothing is pushed
   assign wid = wen ? sel : TGT_ITCM;

   assign push_entry.target_id = wid;
   assign push_entry.reg_index = cur.cmd_reg_index;
   assign push_entry.reg_write = cur.cmd_reg_write;

   // Bypass the queue when it is empty
   assign eff_head = q_status.empty ? push_entry : q_head;

   always_comb begin
      calc.target_cmd_valid       = cmd_valid ? sel_onehot : 3'b000;
      calc.target_cmd_read        = cmd_valid && (cur.operation == OP_READ);
      calc.target_cmd_address     = cmd_valid ? cur.cmd_address : 32'd0;
      calc.target_cmd_write_data  = cmd_valid ? cur.cmd_write_data : 32'd0;
      calc.target_cmd_byte_enable = cmd_valid ? cur.cmd_byte_enable : 4'd0;
      calc.cmd_ready              = wen;
      calc.rsp_reg_index          = eff_head.reg_index;
      calc.rsp_reg_write          = eff_head.reg_write;
      unique case (eff_head.target_id)
         TGT_ITCM: begin
            calc.rsp_valid        = cur.target_rsp_valid[0];
            calc.rsp_data         = cur.itcm_rsp_data;
            calc.target_rsp_ready = cur.rsp_ready ? 3'b001 : 3'b000;
         end
         TGT_DTCM: begin
            calc.rsp_valid        = cur.target_rsp_valid[1];
            calc.rsp_data         = cur.dtcm_rsp_data;
            calc.target_rsp_ready = cur.rsp_ready ? 3'b010 : 3'b000;
         end
         TGT_BUS: begin
            calc.rsp_valid        = cur.target_rsp_valid[2];
            calc.rsp_data         = cur.bus_rsp_data;
            calc.target_rsp_ready = cur.rsp_ready ? 3'b100 : 3'b000;
         end
         default: begin
            calc.rsp_valid        = 1'b0;
            calc.rsp_data         = 32'd0;
            calc.target_rsp_ready = 3'b000;
         end
      endcase
   end

   // A stray response on an empty queue is reported but does not advance the head
   assign ren = calc.rsp_valid && cur.rsp_ready && (!q_status.empty || wen);

   lsbs_order_queue u_order_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (adv && wen),
      .pop        (adv && ren),
      .push_entry (push_entry),
      .head       (q_head),
      .status     (q_status)
   );

   // Result register: load on advance, drop once taken
   assign out_valid_in = adv ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= calc;
      end
   end

`ifndef NO_ASSERTIONS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> $onehot0(rsp_if.payload.target_cmd_valid))
      else $error("command valid is not one-hot");

   a_rsp_ready_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> $onehot0(rsp_if.payload.target_rsp_ready))
      else $error("response ready is not one-hot");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (adv && q_status.full) |=> (out_data_ff.target_cmd_valid == 3'b000))
      else $error("command offered while the order queue is full");

   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      (adv && wen && !ren) |=> !q_status.empty)
      else $error("order queue empty after a push");

   a_ready_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.cmd_ready |-> rsp_if.payload.target_cmd_valid != 3'b000)
      else $error("command accepted without being offered");
`endif

endmodule

`default_nettype wire

/* dv/load_store_bus_splitter_tb.sv */
// Self-checking testbench of the load/store bus splitter: routing, order queue and
// response steering, checked word by word against a cycle predictor kept in the bench.
// Depends on lsbs_pkg, lsbs_ifs and the load_store_bus_splitter RTL.
module load_store_bus_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbs_pkg::*;

   // Operation code 3 is not in the package enum; the block treats it as no command
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam int REQ_W = $bits(req_type);

   // Shapes of generated traffic
   typedef enum int {
      MIX_TRAFFIC,
      FILL_TRAFFIC,
      DRAIN_TRAFFIC,
      NOISE_TRAFFIC
   } traffic_type;

   localparam int HOLDOFF_CYCLES = 60;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0] csr_write_data;

   lsbs_req_if req_ch ();
   lsbs_rsp_if rsp_ch ();

   load_store_bus_splitter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Words waiting to be offered, and results the predictor says must come back
   req_type pending_cmds[$];
   rsp_type routed_results[$];

   // Bench copy of the base registers and of the order queue
   logic [7:0] itcm_base_copy;
   logic [7:0] dtcm_base_copy;
   logic [1:0] ord_target[QUEUE_DEPTH];
   logic [4:0] ord_reg_index[QUEUE_DEPTH];
   logic       ord_reg_write[QUEUE_DEPTH];
   logic [PTR_W-1:0] ord_wr;
   logic [PTR_W-1:0] ord_rd;

   int tx_idle_pct;
   int rx_idle_pct;
   int mismatches;
   int words_checked;
   int cmds_queued;
   int rsps_retired;
   int full_blocks;

   logic word_taken;
   logic holdoff_req;
   logic holdoff_seen;
   int   holdoff_left;

   // Advance the predicted splitter by one word; return the result it must give
   function automatic void route_word(input req_type w, output rsp_type r);
      logic [PTR_W-1:0] nwp;
      logic is_full, is_empty, cmd_live, cmd_taken, rsp_taken;
      target_type sel;
      logic [1:0] wid, head_tgt;
      begin
         nwp      = (ord_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ord_wr + 1'b1;
         is_full  = (nwp == ord_rd);
         is_empty = (ord_wr == ord_rd);
         cmd_live = (w.operation == OP_READ || w.operation == OP_WRITE) && !is_full;
         if (w.operation inside {OP_READ, OP_WRITE} && is_full)
            full_blocks++;

         // ITCM base takes precedence when both bases match
         if (w.cmd_address[31:24] == itcm_base_copy)
            sel = TGT_ITCM;
         else if (w.cmd_address[31:24] == dtcm_base_copy)
            sel = TGT_DTCM;
         else
            sel = TGT_BUS;

         cmd_taken = cmd_live && w.target_cmd_ready[sel];
         // the queued id is zero unless a command goes in this cycle
         wid = cmd_taken ? sel : TGT_ITCM;

         r = '0;
         if (cmd_live) begin
            r.target_cmd_valid       = 3'b001 << sel;
            r.target_cmd_read        = (w.operation == OP_READ);
            r.target_cmd_address     = w.cmd_address;
            r.target_cmd_write_data  = w.cmd_write_data;
            r.target_cmd_byte_enable = w.cmd_byte_enable;
         end
         r.cmd_ready = cmd_taken;

         // empty queue: the word's own command stands in for the head
         if (is_empty) begin
            head_tgt        = wid;
            r.rsp_reg_index = w.cmd_reg_index;
            r.rsp_reg_write = w.cmd_reg_write;
         end else begin
            head_tgt        = ord_target[ord_rd];
            r.rsp_reg_index = ord_reg_index[ord_rd];
            r.rsp_reg_write = ord_reg_write[ord_rd];
         end

         case (head_tgt)
            TGT_ITCM: r.rsp_data = w.itcm_rsp_data;
            TGT_DTCM: r.rsp_data = w.dtcm_rsp_data;
            default:  r.rsp_data = w.bus_rsp_data;
         endcase
         r.rsp_valid        = w.target_rsp_valid[head_tgt];
         r.target_rsp_ready = w.rsp_ready ? (3'b001 << head_tgt) : 3'b000;

         // a stray response on an empty queue is passed on but retires nothing
         rsp_taken = r.rsp_valid && w.rsp_ready && (!is_empty || cmd_taken);

         if (cmd_taken) begin
            ord_target[ord_wr]    = wid;
            ord_reg_index[ord_wr] = w.cmd_reg_index;
            ord_reg_write[ord_wr] = w.cmd_reg_write;
            ord_wr = nwp;
            cmds_queued++;
         end
         if (rsp_taken) begin
            ord_rd = (ord_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ord_rd + 1'b1;
            rsps_retired++;
         end
      end
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   // Build one word; the three read data buses are always random
   function automatic req_type make_word(input logic [1:0] op, input logic [31:0] addr,
                                         input logic [3:0] be, input logic [4:0] idx,
                                         input logic rwr, input logic [2:0] cready,
                                         input logic [2:0] rvalid, input logic rready);
      req_type w;
      begin
         w.operation        = op;
         w.cmd_address      = addr;
         w.cmd_write_data   = $urandom;
         w.cmd_byte_enable  = be;
         w.cmd_reg_index    = idx;
         w.cmd_reg_write    = rwr;
         w.target_cmd_ready = cready;
         w.target_rsp_valid = rvalid;
         w.itcm_rsp_data    = $urandom;
         w.dtcm_rsp_data    = $urandom;
         w.bus_rsp_data     = $urandom;
         w.rsp_ready        = rready;
         return w;
      end
   endfunction

   // Steer most addresses at the two memories so all three targets stay busy
   function automatic logic [31:0] pick_address();
      int roll;
      logic [31:0] a;
      begin
         roll = $urandom_range(99);
         a    = $urandom;
         if (roll < 35)
            a[31:24] = itcm_base_copy;
         else if (roll < 65)
            a[31:24] = dtcm_base_copy;
         return a;
      end
   endfunction

   function automatic req_type random_word(input traffic_type kind);
      req_type w;
      int roll;
      logic [1:0] op;
      logic [2:0] cready, rvalid;
      logic rready;
      begin
         roll = $urandom_range(99);
         if (kind == DRAIN_TRAFFIC)
            op = (roll < 70) ? OP_NONE : ((roll < 85) ? OP_READ : OP_WRITE);
         else if (roll < 6)
            op = OP_NONE;
         else if (roll < 10)
            op = OP_RESERVED;
         else if (roll < 55)
            op = OP_READ;
         else
            op = OP_WRITE;

         case (kind)
            FILL_TRAFFIC: begin
               cready = ($urandom_range(9) < 8) ? 3'b111 : 3'($urandom);
               rvalid = ($urandom_range(9) < 7) ? 3'b000 : 3'($urandom);
               rready = 1'($urandom_range(1));
            end
            DRAIN_TRAFFIC: begin
               cready = 3'($urandom);
               rvalid = ($urandom_range(9) < 8) ? 3'b111 : 3'($urandom);
               rready = ($urandom_range(9) < 9);
            end
            default: begin
               cready = 3'($urandom) | 3'($urandom);
               rvalid = 3'($urandom);
               rready = ($urandom_range(9) < 7);
            end
         endcase

         w = make_word(op, pick_address(), 4'($urandom), 5'($urandom), 1'($urandom),
                       cready, rvalid, rready);
         // noise: every field free, including the raw operation bits
         if (kind == NOISE_TRAFFIC)
            w = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom});
         return w;
      end
   endfunction

   // Queue runs of fill and drain traffic with mixed and noise words between them
   task automatic queue_random_traffic(input int count);
      int made, run;
      traffic_type kind;
      begin
         made = 0;
         while (made < count) begin
            case ($urandom_range(9))
               0, 1, 2: kind = FILL_TRAFFIC;
               3, 4, 5: kind = DRAIN_TRAFFIC;
               6:       kind = NOISE_TRAFFIC;
               default: kind = MIX_TRAFFIC;
            endcase
            run = (kind == NOISE_TRAFFIC) ? $urandom_range(1, 3) : $urandom_range(3, 10);
            repeat (run) begin
               pending_cmds.push_back(random_word(kind));
               made++;
            end
         end
      end
   endtask

   // Hold until no word is queued, offered or in flight; returns on a falling edge
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_cmds.size() != 0 || req_ch.valid || routed_results.size() != 0);
   endtask

   // Drain, let the pipeline settle, then write both base registers
   task automatic set_bases(input logic [7:0] itcm, input logic [7:0] dtcm);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ITCM_BASE;
      csr_write_data   <= itcm;
      @(negedge clock);
      csr_index        <= CSR_DTCM_BASE;
      csr_write_data   <= dtcm;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      itcm_base_copy = itcm;
      dtcm_base_copy = dtcm;
      @(posedge clock);
   endtask

   // Driver: hold a word until taken, then advance to the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.payload <= '0;
      end else if (!req_ch.valid || word_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_ch.payload <= pending_cmds.pop_front();
            req_ch.valid   <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         holdoff_left <= 0;
         holdoff_seen <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (holdoff_req != holdoff_seen) begin
         holdoff_seen <= holdoff_req;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Monitor: predict on every accepted input word, check every accepted result
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            route_word(req_ch.payload, want);
            routed_results.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (routed_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: result word with none expected, got %h", $time, got);
            end else begin
               want = routed_results.pop_front();
               words_checked++;
               check_field("target_cmd_valid", 32'(want.target_cmd_valid),
                           32'(got.target_cmd_valid));
               check_field("target_cmd_read", 32'(want.target_cmd_read),
                           32'(got.target_cmd_read));
               check_field("target_cmd_address", want.target_cmd_address,
                           got.target_cmd_address);
               check_field("target_cmd_write_data", want.target_cmd_write_data,
                           got.target_cmd_write_data);
               check_field("target_cmd_byte_enable", 32'(want.target_cmd_byte_enable),
                           32'(got.target_cmd_byte_enable));
               check_field("cmd_ready", 32'(want.cmd_ready), 32'(got.cmd_ready));
               check_field("rsp_valid", 32'(want.rsp_valid), 32'(got.rsp_valid));
               check_field("rsp_data", want.rsp_data, got.rsp_data);
               check_field("rsp_reg_index", 32'(want.rsp_reg_index),
                           32'(got.rsp_reg_index));
               check_field("rsp_reg_write", 32'(want.rsp_reg_write),
                           32'(got.rsp_reg_write));
               check_field("target_rsp_ready", 32'(want.target_rsp_ready),
                           32'(got.target_rsp_ready));
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      req_type w;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ITCM_BASE;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.payload   = '0;
      rsp_ch.ready     = 1'b0;
      holdoff_req      = 1'b0;
      itcm_base_copy   = ITCM_BASE_RESET;
      dtcm_base_copy   = DTCM_BASE_RESET;
      ord_wr           = '0;
      ord_rd           = '0;
      tx_idle_pct      = 8;
      rx_idle_pct      = 55;
      mismatches       = 0;
      words_checked    = 0;
      cmds_queued      = 0;
      rsps_retired     = 0;
      full_blocks      = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: reset bases, sender rarely idles, receiver often stalls
      set_bases(ITCM_BASE_RESET, DTCM_BASE_RESET);
      // empty-queue bypass into each target, field extremes
      pending_cmds.push_back(make_word(OP_READ, 32'h80_00_00_04, 4'hF, 5'd1, 1'b1,
                                       3'b111, 3'b111, 1'b1));
      pending_cmds.push_back(make_word(OP_WRITE, 32'h90_12_34_58, 4'h3, 5'd2, 1'b0,
                                       3'b111, 3'b111, 1'b1));
      w = make_word(OP_READ, 32'hFFFF_FFFF, 4'hF, 5'd31, 1'b1, 3'b111, 3'b111, 1'b1);
      w.cmd_write_data = '1;
      w.bus_rsp_data   = '1;
      pending_cmds.push_back(w);
      w = make_word(OP_WRITE, 32'h0, 4'h0, 5'd0, 1'b0, 3'b111, 3'b000, 1'b0);
      w.cmd_write_data = '0;
      w.bus_rsp_data   = '0;
      pending_cmds.push_back(w);
      // reserved operation and a stray response on an empty queue
      pending_cmds.push_back(make_word(OP_RESERVED, 32'h80_00_00_00, 4'hA, 5'd7, 1'b1,
                                       3'b111, 3'b111, 1'b1));
      pending_cmds.push_back(make_word(OP_NONE, 32'h90_00_00_00, 4'h5, 5'd9, 1'b0,
                                       3'b111, 3'b010, 1'b1));
      // fill the order queue to full, then offer into the full queue
      pending_cmds.push_back(make_word(OP_READ, 32'h80_00_01_00, 4'hF, 5'd10, 1'b1,
                                       3'b111, 3'b000, 1'b0));
      pending_cmds.push_back(make_word(OP_WRITE, 32'h90_00_02_00, 4'h1, 5'd11, 1'b0,
                                       3'b111, 3'b000, 1'b1));
      pending_cmds.push_back(make_word(OP_READ, 32'h40_00_03_00, 4'h2, 5'd12, 1'b1,
                                       3'b111, 3'b000, 1'b0));
      pending_cmds.push_back(make_word(OP_READ, 32'h80_00_04_00, 4'h4, 5'd13, 1'b1,
                                       3'b111, 3'b000, 1'b1));
      pending_cmds.push_back(make_word(OP_WRITE, 32'h90_00_05_00, 4'h8, 5'd14, 1'b0,
                                       3'b111, 3'b110, 1'b1));
      // drain in order, with head response not valid once
      pending_cmds.push_back(make_word(OP_NONE, 32'h0, 4'h0, 5'd15, 1'b0,
                                       3'b000, 3'b111, 1'b1));
      pending_cmds.push_back(make_word(OP_NONE, 32'h0, 4'h0, 5'd16, 1'b0,
                                       3'b000, 3'b101, 1'b1));
      pending_cmds.push_back(make_word(OP_READ, 32'h40_00_06_00, 4'hC, 5'd17, 1'b1,
                                       3'b111, 3'b111, 1'b1));
      pending_cmds.push_back(make_word(OP_NONE, 32'h0, 4'h0, 5'd18, 1'b0,
                                       3'b000, 3'b111, 1'b1));
      // target not ready: command offered but not queued
      pending_cmds.push_back(make_word(OP_READ, 32'h80_00_07_00, 4'hF, 5'd19, 1'b1,
                                       3'b110, 3'b111, 1'b1));
      pending_cmds.push_back(make_word(OP_WRITE, 32'h22_00_08_00, 4'hF, 5'd20, 1'b1,
                                       3'b011, 3'b100, 1'b0));
      queue_random_traffic(100);

      // Phase 2: extreme bases, roles of the two sides swapped
      set_bases(8'h00, 8'hFF);
      tx_idle_pct = 55;
      rx_idle_pct = 8;
      queue_random_traffic(100);

      // Phase 3: equal bases, no idling, long receiver hold-off to back up the input
      set_bases(8'h42, 8'h42);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      pending_cmds.push_back(make_word(OP_READ, 32'h42_00_00_10, 4'hF, 5'd21, 1'b1,
                                       3'b111, 3'b111, 1'b1));
      pending_cmds.push_back(make_word(OP_WRITE, 32'h42_00_00_20, 4'h6, 5'd22, 1'b0,
                                       3'b110, 3'b111, 1'b1));
      queue_random_traffic(70);
      @(negedge clock);
      holdoff_req <= 1'b1;

      // Phase 4: extremes the other way, pause midway until everything is back
      set_bases(8'hFF, 8'h00);
      queue_random_traffic(40);
      wait_drained();
      @(posedge clock);
      queue_random_traffic(40);

      // Phase 5: random bases
      set_bases(8'($urandom), 8'($urandom));
      queue_random_traffic(60);

      wait_drained();
      repeat (8) @(negedge clock);
      if (routed_results.size() != 0) begin
         mismatches++;
         $display("%0t ns: %0d expected results never arrived", $time, routed_results.size());
      end

      $display("Checked %0d result words; %0d commands queued, %0d responses retired,",
               words_checked, cmds_queued, rsps_retired);
      $display("%0d commands held back by a full order queue, 5 base settings.", full_blocks);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #400000;
      $display("%0t ns: timeout, %0d words still pending, %0d results outstanding",
               $time, pending_cmds.size(), routed_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
